// ===== rtl/pta_pkg.sv =====
package pta_pkg;

  localparam int unsigned SLOTS_DEF = 4;
  localparam int unsigned HEADER_BYTES_DEF = 128;

  typedef enum logic [1:0] {
    FUNC_PRIMARY  = 2'd0,
    FUNC_EXTENDED = 2'd1,
    FUNC_RESIZE   = 2'd2,
    FUNC_DELETE   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_SMALL = 3'd1,
    ST_NO_SPACE  = 3'd2,
    ST_NAME_EXISTS = 3'd3,
    ST_TABLE_FULL  = 3'd4,
    ST_EXT_EXISTS  = 3'd5,
    ST_NOT_FOUND   = 3'd6,
    ST_NO_ROOM     = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_e;

  localparam logic CFG_DISK_SIZE = 1'b0;
  localparam logic CFG_FIT_MODE  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_DECIDE,
    S_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic scan_init;
    logic scan_step;
    logic scan_last;
    logic decide;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
  } stat_t;

endpackage

// ===== rtl/pta_ctrl.sv =====
module pta_ctrl
  import pta_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cmd_o.scan_init = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.scan_done) begin
          state_d = S_LAST;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_LAST: begin
        cmd_o.scan_last = 1'b1;
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/pta_datapath.sv =====
module pta_datapath
  import pta_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF,
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic [1:0]  func_i,
  input  logic [31:0] size_amount_i,
  input  logic [1:0]  size_unit_i,
  input  logic [63:0] name_low_i,
  input  logic [63:0] name_high_i,
  output logic [2:0]  status_o,
  output logic [31:0] start_address_o,
  output logic [1:0]  slot_o
);

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  logic [31:0] disk_size_q;
  logic [1:0]  fit_q;

  logic [SLOTS-1:0] act_q, ext_q;
  logic [31:0] st_q [SLOTS];
  logic [31:0] sz_q [SLOTS];
  logic [63:0] nl_q [SLOTS];
  logic [63:0] nh_q [SLOTS];

  logic [1:0]  func_q;
  logic signed [53:0] bytes_q;
  logic [63:0] lo_q, hi_q;

  logic [SLOTS-1:0] seen_q;
  logic [CW-1:0]    cnt_q;
  logic [32:0]      cur_q;
  logic             gf_q;
  logic [32:0]      gs_q, gl_q;

  logic [2:0]  status_q;
  logic [31:0] start_q;
  logic [1:0]  slot_q;

  logic [32:0] dend;
  assign dend = ({1'b0, disk_size_q} + 33'(HEADER_BYTES) > 33'h0FFFFFFFF) ?
                33'h0FFFFFFFF : ({1'b0, disk_size_q} + 33'(HEADER_BYTES));

  logic signed [53:0] bytes_c;
  always_comb begin
    case (size_unit_i)
      2'd1:    bytes_c = 54'(signed'(size_amount_i)) <<< 10;
      2'd2:    bytes_c = 54'(signed'(size_amount_i)) <<< 20;
      default: bytes_c = 54'(signed'(size_amount_i));
    endcase
  end

  // Smallest unseen active start.
  logic          pick_ok;
  logic [SW-1:0] pick;
  always_comb begin
    pick_ok = 1'b0;
    pick = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (act_q[i] && !seen_q[i] && (!pick_ok || st_q[i] < st_q[pick])) begin
        pick_ok = 1'b1;
        pick = SW'(i);
      end
    end
  end
  assign stat_o.scan_done = !pick_ok || (cnt_q == CW'(SLOTS));

  logic [32:0] ge;
  assign ge = cmd_i.scan_last ? dend : {1'b0, st_q[pick]};

  logic [32:0] len;
  logic        take;
  always_comb begin
    len = ge - cur_q;
    take = 1'b0;
    if (ge > cur_q && $signed({21'd0, len}) >= bytes_q) begin
      if (!gf_q) take = 1'b1;
      else if (fit_q == FIT_BEST && len < gl_q) take = 1'b1;
      else if (fit_q == FIT_WORST && len > gl_q) take = 1'b1;
    end
  end

  logic [32:0] pend;
  assign pend = {1'b0, st_q[pick]} + {1'b0, sz_q[pick]};

  logic          fnd;
  logic [SW-1:0] fidx;
  logic          free_ok, ext_any;
  logic [SW-1:0] free_idx;
  always_comb begin
    fnd = 1'b0; fidx = '0; free_ok = 1'b0; free_idx = '0; ext_any = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (act_q[i] && nl_q[i] == lo_q && nh_q[i] == hi_q) begin
        fnd = 1'b1; fidx = SW'(i);
      end
      if (!act_q[i]) begin
        free_ok = 1'b1; free_idx = SW'(i);
      end
      if (act_q[i] && ext_q[i]) ext_any = 1'b1;
    end
  end

  logic [32:0] limit;
  always_comb begin
    limit = dend;
    for (int i = 0; i < SLOTS; i++) begin
      if (SW'(i) != fidx && act_q[i] && st_q[i] >= st_q[fidx] &&
          {1'b0, st_q[i]} < limit) begin
        limit = {1'b0, st_q[i]};
      end
    end
  end
  logic signed [54:0] nsize;
  assign nsize = 55'(signed'({1'b0, sz_q[fidx]})) + 55'(bytes_q);
  logic [55:0] rend;
  assign rend = 56'(st_q[fidx]) + 56'(nsize);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disk_size_q <= '0;
      fit_q <= '0;
      act_q <= '0;
      ext_q <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        st_q[i] <= '0; sz_q[i] <= '0; nl_q[i] <= '0; nh_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_DISK_SIZE) disk_size_q <= cfg_data_i;
        else fit_q <= cfg_data_i[1:0];
      end
      if (cmd_i.decide) begin
        if (func_q == FUNC_PRIMARY || func_q == FUNC_EXTENDED) begin
          if (bytes_q > 0 && gf_q && !(func_q == FUNC_EXTENDED && ext_any) &&
              !fnd && free_ok) begin
            act_q[free_idx] <= 1'b1;
            ext_q[free_idx] <= (func_q == FUNC_EXTENDED);
            st_q[free_idx] <= gs_q[31:0];
            sz_q[free_idx] <= bytes_q[31:0];
            nl_q[free_idx] <= lo_q;
            nh_q[free_idx] <= hi_q;
          end
        end else if (func_q == FUNC_RESIZE) begin
          if (fnd && nsize > 0 && rend <= 56'(limit)) sz_q[fidx] <= nsize[31:0];
        end else if (fnd) begin
          act_q[fidx] <= 1'b0; ext_q[fidx] <= 1'b0;
          st_q[fidx] <= '0; sz_q[fidx] <= '0; nl_q[fidx] <= '0; nh_q[fidx] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0; cnt_q <= '0; cur_q <= '0; gf_q <= 1'b0; gs_q <= '0; gl_q <= '0;
    end else begin
      if (cmd_i.scan_init) begin
        seen_q <= '0; cnt_q <= '0; cur_q <= 33'(HEADER_BYTES);
        gf_q <= 1'b0; gs_q <= '0; gl_q <= '0;
      end else if (cmd_i.scan_step || cmd_i.scan_last) begin
        if (take) begin
          gf_q <= 1'b1; gs_q <= cur_q; gl_q <= len;
        end
        if (cmd_i.scan_step) begin
          seen_q[pick] <= 1'b1;
          cnt_q <= cnt_q + 1'b1;
          if (pend > cur_q) cur_q <= pend;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i; bytes_q <= bytes_c; lo_q <= name_low_i; hi_q <= name_high_i;
    end
    if (cmd_i.decide) begin
      status_q <= ST_OK; start_q <= '0; slot_q <= '0;
      if (func_q == FUNC_PRIMARY || func_q == FUNC_EXTENDED) begin
        if (bytes_q <= 0) status_q <= ST_TOO_SMALL;
        else if (!gf_q) status_q <= ST_NO_SPACE;
        else if (func_q == FUNC_EXTENDED && ext_any) status_q <= ST_EXT_EXISTS;
        else if (fnd) status_q <= ST_NAME_EXISTS;
        else if (!free_ok) status_q <= ST_TABLE_FULL;
        else begin
          start_q <= gs_q[31:0]; slot_q <= 2'(free_idx);
        end
      end else if (!fnd) begin
        status_q <= ST_NOT_FOUND;
      end else if (func_q == FUNC_RESIZE) begin
        slot_q <= 2'(fidx);
        if (nsize <= 0) status_q <= ST_TOO_SMALL;
        else if (rend > 56'(limit)) status_q <= ST_NO_ROOM;
        else start_q <= st_q[fidx];
      end else begin
        slot_q <= 2'(fidx); start_q <= st_q[fidx];
      end
    end
  end

  assign status_o = status_q;
  assign start_address_o = start_q;
  assign slot_o = slot_q;

endmodule

// ===== rtl/partition_table_allocator.sv =====
// Partition table allocator with a small table of partition entries.
// Commands arrive as beats on the s_axis channel: tuser carries the
// function code, tdata the size, unit and 16-byte name. Each command
// yields one result beat on m_axis with status, start address and slot.
// The user writes configuration (disk size, fit mode) over the cfg
// channel only while no command is in flight; the block does not check.
// After acceptance, the gap scan walks the active entries (at most
// SLOTS) in address order, one entry per cycle, through a shared
// compare unit, then checks the last gap up to the disk end.
// One command is processed at a time; the next is accepted the cycle
// after the result beat is taken.
// Reset clears the table, config and scan state at once; no sweep is needed.
// When the receiver stalls, the result is held on m_axis and no new
// command is accepted until it is taken.
module partition_table_allocator
  import pta_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF,
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // size_amount[31:0], size_unit[33:32], name_low[97:34], name_high[161:98]
  input  logic [167:0] s_axis_tdata,
  // func[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0], start_address[34:3], slot[36:35]
  output logic [39:0]  m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  cmd_t  cmd;
  stat_t stat;
  logic [2:0]  status;
  logic [31:0] start_address;
  logic [1:0]  slot;

  assign cfg_ready_o = 1'b1;

  pta_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  pta_datapath #(
    .SLOTS        (SLOTS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_valid_i),
    .cfg_idx_i       (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .func_i          (s_axis_tuser),
    .size_amount_i   (s_axis_tdata[31:0]),
    .size_unit_i     (s_axis_tdata[33:32]),
    .name_low_i      (s_axis_tdata[97:34]),
    .name_high_i     (s_axis_tdata[161:98]),
    .status_o        (status),
    .start_address_o (start_address),
    .slot_o          (slot)
  );

  assign m_axis_tdata = {3'b000, slot, start_address, status};

endmodule
